// File: hw/rtl/knps_pkg.sv
// Shared types, constants and helper functions of the k-nearest point select unit.
package knps_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int K_MAX      = 16;
  localparam int COORD_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_POINTS);
  localparam int COUNT_W = $clog2(MAX_POINTS + 1);
  localparam int KCNT_W  = $clog2(K_MAX + 1);
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int DIST_W  = SQ_W + 2;
  localparam int RANK_W  = 4;
  localparam int CFG_W   = 5;
  localparam int FIELD_COORD_W = 16;
  localparam int FIELD_IDX_W   = 10;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_W-1:0] NC_RESET = CFG_W'(3);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [1:0]                      op;
    logic signed [FIELD_COORD_W-1:0] coord_x;
    logic signed [FIELD_COORD_W-1:0] coord_y;
    logic signed [FIELD_COORD_W-1:0] coord_z;
    logic                            skip_valid;
    logic [FIELD_IDX_W-1:0]          skip_index;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0] neighbor_index;
    logic [DIST_W-1:0]      neighbor_dist_sq;
    logic [RANK_W-1:0]      neighbor_rank;
    logic                   last;
  } out_item_t;

  // One slot of the sorted neighbor list.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] sq_dist;
    logic [IDX_W-1:0]  idx;
  } cell_entry_t;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } cell_ctrl_t;

  // Magnitude of the difference of two coordinates; it always fits COORD_BITS unsigned bits.
  function automatic logic [COORD_BITS-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_BITS:0] d;
    logic        [COORD_BITS:0] n;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    n = ~d + 1'b1;
    abs_diff = d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

endpackage

// File: hw/rtl/knps_dist_pipe.sv
// Point table memory and the pipelined squared-distance datapath.
module knps_dist_pipe
  import knps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  point_t           wr_point,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  point_t           query_pt,
  output cell_entry_t      cand,
  output logic             pipe_busy
);

  point_t mem [MAX_POINTS];

  point_t             rd_pt_r;
  logic               v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r, idx3_r, idx4_r;
  logic [COORD_BITS-1:0] ax_r, ay_r, az_r;
  logic [SQ_W-1:0]    sx_r, sy_r, sz_r;
  logic [DIST_W-1:0]  dist_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pt_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= rd_addr;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    ax_r   <= abs_diff(query_pt.x, rd_pt_r.x);
    ay_r   <= abs_diff(query_pt.y, rd_pt_r.y);
    az_r   <= abs_diff(query_pt.z, rd_pt_r.z);
    sx_r   <= ax_r * ax_r;
    sy_r   <= ay_r * ay_r;
    sz_r   <= az_r * az_r;
    dist_r <= DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  end

  assign cand.valid   = v4_r;
  assign cand.sq_dist = dist_r;
  assign cand.idx     = idx4_r;
  assign pipe_busy    = v1_r | v2_r | v3_r | v4_r;

endmodule

// File: hw/rtl/knps_cell.sv
// One slot of the sorted insertion chain of nearest neighbors.
module knps_cell
  import knps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctrl_t  ctrl,
  input  logic        en,
  input  cell_entry_t cand,
  input  cell_entry_t prev_ent,
  input  logic        prev_less,
  input  cell_entry_t next_ent,
  output cell_entry_t ent,
  output logic        less
);

  cell_entry_t ent_r, ent_nxt;

  // An empty slot ranks behind every candidate; equal distances keep the older point first.
  assign less = en & (~ent_r.valid | (cand.sq_dist < ent_r.sq_dist));

  always_comb begin
    ent_nxt = ent_r;
    priority if (ctrl.clear) begin
      ent_nxt.valid = 1'b0;
    end else if (ctrl.shift) begin
      ent_nxt = next_ent;
    end else if (ctrl.insert && en) begin
      if (prev_less) begin
        ent_nxt = prev_ent;
      end else if (less) begin
        ent_nxt       = cand;
        ent_nxt.valid = 1'b1;
      end
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.sq_dist <= ent_nxt.sq_dist;
    ent_r.idx     <= ent_nxt.idx;
  end

  assign ent = ent_r;

endmodule

// File: hw/rtl/knps_cell_chain.sv
// Row of sorter cells holding the k best neighbors, nearest at the head.
module knps_cell_chain
  import knps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic [K_MAX-1:0] cell_en,
  input  cell_entry_t      cand,
  output cell_entry_t      head,
  output logic             second_valid
);

  cell_entry_t ent  [K_MAX];
  cell_entry_t prv  [K_MAX];
  cell_entry_t nxt  [K_MAX];
  logic        less [K_MAX];
  logic        prv_less [K_MAX];

  localparam cell_entry_t EMPTY = '0;

  for (genvar j = 0; j < K_MAX; j++) begin : g_cell
    if (j == 0) begin : g_first
      assign prv[j]      = EMPTY;
      assign prv_less[j] = 1'b0;
    end else begin : g_mid
      assign prv[j]      = ent[j-1];
      assign prv_less[j] = less[j-1];
    end
    if (j == K_MAX - 1) begin : g_last
      assign nxt[j] = EMPTY;
    end else begin : g_inner
      assign nxt[j] = ent[j+1];
    end

    knps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .en        (cell_en[j]),
      .cand      (cand),
      .prev_ent  (prv[j]),
      .prev_less (prv_less[j]),
      .next_ent  (nxt[j]),
      .ent       (ent[j]),
      .less      (less[j])
    );
  end

  assign head = ent[0];

  if (K_MAX > 1) begin : g_second
    assign second_valid = ent[1].valid;
  end else begin : g_single
    assign second_valid = 1'b0;
  end

endmodule

// File: hw/rtl/k_nearest_point_select_unit.sv
// Top level of the k-nearest point select unit: command port, sequencer and result register.
//
// The unit keeps a table of up to MAX_POINTS (1024) 3D points and answers brute-force
// k-nearest-neighbor queries over it. A transaction is accepted when start is high and busy
// is low; in_item.op selects a load (append one point, ignored once the table is full), a
// query, or a clear of the table. Loads and clears produce no result. A query scans every
// stored point once through the read port of the point memory, one point per cycle,
// followed by a four-stage distance pipeline, and keeps busy high until its results have
// been sent. The memory read port sets the scan rate. The n = min(k, eligible points) results
// then leave one per cycle on out_item, each marked by out_valid for exactly one cycle,
// nearest first, with ties going to the point stored earlier, and the final one carrying
// last; it appears in the same cycle as busy falls. The receiver has no way to stall these
// results, so it must take them as they come. The number k comes from the neighbor count
// register (cfg_we, cfg_wdata; reset value 3); zero acts as one and values above K_MAX act
// as K_MAX. Write it only while the unit is idle. A query on an empty table returns no
// result. Table entries are not initialized after reset; only loaded entries are ever read.
module k_nearest_point_select_unit
  import knps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] scan_idx_r, scan_idx_nxt;
  point_t             q_pt_r, q_pt_nxt;
  logic               skip_valid_r, skip_valid_nxt;
  logic [IDX_W-1:0]   skip_idx_r, skip_idx_nxt;
  logic [K_MAX-1:0]   cell_en_r, cell_en_nxt;
  logic [RANK_W-1:0]  rank_r, rank_nxt;
  logic [CFG_W-1:0]   nc_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               accept;
  logic               wr_en;
  point_t             in_pt;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  cell_entry_t        cand;
  logic               pipe_busy;
  cell_ctrl_t         chain_ctrl;
  cell_entry_t        head;
  logic               second_valid;
  logic [KCNT_W-1:0]  k_eff;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign in_pt.x = in_item.coord_x[COORD_BITS-1:0];
  assign in_pt.y = in_item.coord_y[COORD_BITS-1:0];
  assign in_pt.z = in_item.coord_z[COORD_BITS-1:0];

  // A load lands at the current fill position as long as the table has room.
  assign wr_en = accept && (in_item.op == OP_LOAD) && (count_r < COUNT_W'(MAX_POINTS));

  // Out-of-range neighbor counts are clamped into one to K_MAX.
  always_comb begin
    priority if (nc_r == '0) begin
      k_eff = KCNT_W'(1);
    end else if (int'(nc_r) > K_MAX) begin
      k_eff = KCNT_W'(K_MAX);
    end else begin
      k_eff = KCNT_W'(nc_r);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= NC_RESET;
    end else if (cfg_we) begin
      nc_r <= cfg_wdata;
    end
  end

  // Sequencer: scan issues one memory read per cycle, drain waits for the distance pipeline
  // to empty into the cell chain, and emit shifts the chain out through the result register.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    q_pt_nxt       = q_pt_r;
    skip_valid_nxt = skip_valid_r;
    skip_idx_nxt   = skip_idx_r;
    cell_en_nxt    = cell_en_r;
    rank_nxt       = rank_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;
    rd_en          = 1'b0;
    rd_addr        = scan_idx_r[IDX_W-1:0];
    chain_ctrl     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.op)
            OP_LOAD: begin
              if (wr_en) begin
                count_nxt = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              q_pt_nxt         = in_pt;
              skip_valid_nxt   = in_item.skip_valid;
              skip_idx_nxt     = IDX_W'(in_item.skip_index);
              scan_idx_nxt     = '0;
              rank_nxt         = '0;
              chain_ctrl.clear = 1'b1;
              for (int j = 0; j < K_MAX; j++) begin
                cell_en_nxt[j] = (j < int'(k_eff));
              end
              state_nxt = ST_SCAN;
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_idx_r < count_r) begin
          // The excluded point is stepped over without entering the pipeline.
          rd_en        = !(skip_valid_r && (scan_idx_r[IDX_W-1:0] == skip_idx_r));
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (head.valid) begin
          out_valid_nxt                 = 1'b1;
          out_item_nxt.neighbor_index   = FIELD_IDX_W'(head.idx);
          out_item_nxt.neighbor_dist_sq = head.sq_dist;
          out_item_nxt.neighbor_rank    = rank_r;
          out_item_nxt.last             = !second_valid;
          rank_nxt                      = rank_r + 1'b1;
          chain_ctrl.shift              = 1'b1;
          if (!second_valid) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    chain_ctrl.insert = cand.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      scan_idx_r  <= '0;
      cell_en_r   <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cell_en_r   <= cell_en_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_pt_r       <= q_pt_nxt;
    skip_valid_r <= skip_valid_nxt;
    skip_idx_r   <= skip_idx_nxt;
    out_item_r   <= out_item_nxt;
  end

  knps_dist_pipe u_dist_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (count_r[IDX_W-1:0]),
    .wr_point  (in_pt),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .query_pt  (q_pt_r),
    .cand      (cand),
    .pipe_busy (pipe_busy)
  );

  knps_cell_chain u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (chain_ctrl),
    .cell_en      (cell_en_r),
    .cand         (cand),
    .head         (head),
    .second_valid (second_valid)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A result only ever follows a cycle spent emitting.
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT))
    else $error("result strobe outside the emit phase");

  // The fill count never passes the table capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

  // The first result of a query carries rank zero.
  a_first_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> out_item.neighbor_rank == '0)
    else $error("query results do not start at rank zero");

  // A result without the last mark is followed at once by the next rank.
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |=> out_valid &&
      (out_item.neighbor_rank == RANK_W'($past(out_item.neighbor_rank) + 1'b1)))
    else $error("result sequence broken before the last mark");

  // After the last result the unit falls silent.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("result strobe after the last mark");

endmodule

// File: sim/knps_checker.sv
// Checker for the k-nearest point select unit: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module knps_checker
  import knps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         in_item,
  input  logic             out_valid,
  input  out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               err_count,
  output int               pending,
  output int               results_seen
);

  // Shadow copy of the point table and of the neighbor count register.
  coord_t           tbl_x [MAX_POINTS];
  coord_t           tbl_y [MAX_POINTS];
  coord_t           tbl_z [MAX_POINTS];
  int               tbl_fill;
  logic [CFG_W-1:0] k_setting;

  out_item_t neighbor_expect_q [$];

  function automatic logic [DIST_W-1:0] dist_sq(input coord_t ax, input coord_t ay,
                                                 input coord_t az, input coord_t bx,
                                                 input coord_t by, input coord_t bz);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    dz = longint'(az) - longint'(bz);
    return DIST_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  // Brute-force scan in index order; a strict less-than keeps ties on the earlier point.
  task automatic predict_neighbors(input in_item_t q);
    logic [DIST_W-1:0]      rank_dist [K_MAX];
    logic [FIELD_IDX_W-1:0] rank_slot [K_MAX];
    logic [DIST_W-1:0]      d;
    out_item_t              r;
    int                     k;
    int                     filled;
    int                     j;
    int                     top;
    k = (k_setting == 0) ? 1 : (int'(k_setting) > K_MAX) ? K_MAX : int'(k_setting);
    filled = 0;
    for (int i = 0; i < tbl_fill; i++) begin
      if (q.skip_valid && i == int'(q.skip_index)) continue;
      d = dist_sq(q.coord_x, q.coord_y, q.coord_z, tbl_x[i], tbl_y[i], tbl_z[i]);
      j = 0;
      while (j < filled && d >= rank_dist[j]) j++;
      if (j < k) begin
        top = (filled < k) ? filled : k - 1;
        for (int t = top; t > j; t--) begin
          rank_dist[t] = rank_dist[t-1];
          rank_slot[t] = rank_slot[t-1];
        end
        rank_dist[j] = d;
        rank_slot[j] = FIELD_IDX_W'(i);
        if (filled < k) filled++;
      end
    end
    for (int n = 0; n < filled; n++) begin
      r.neighbor_index   = rank_slot[n];
      r.neighbor_dist_sq = rank_dist[n];
      r.neighbor_rank    = RANK_W'(n);
      r.last             = (n == filled - 1);
      neighbor_expect_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      tbl_fill     = 0;
      k_setting    = NC_RESET;
      err_count    = 0;
      results_seen = 0;
      neighbor_expect_q.delete();
    end else begin
      // Results belong to earlier queries, so they are checked before this edge's input.
      if (out_valid) begin
        results_seen++;
        if (neighbor_expect_q.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected neighbor result idx=%0d dist=%0d rank=%0d last=%0b",
                     $realtime, out_item.neighbor_index, out_item.neighbor_dist_sq,
                     out_item.neighbor_rank, out_item.last);
          err_count++;
        end else begin
          want = neighbor_expect_q.pop_front();
          if (want.neighbor_index !== out_item.neighbor_index ||
              want.neighbor_dist_sq !== out_item.neighbor_dist_sq ||
              want.neighbor_rank !== out_item.neighbor_rank ||
              want.last !== out_item.last) begin
            if (err_count < 10)
              $display("%0t: mismatch expected idx=%0d dist=%0d rank=%0d last=%0b, got idx=%0d dist=%0d rank=%0d last=%0b",
                       $realtime, want.neighbor_index, want.neighbor_dist_sq,
                       want.neighbor_rank, want.last, out_item.neighbor_index,
                       out_item.neighbor_dist_sq, out_item.neighbor_rank, out_item.last);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        case (in_item.op)
          OP_LOAD: begin
            if (tbl_fill < MAX_POINTS) begin
              tbl_x[tbl_fill] = in_item.coord_x;
              tbl_y[tbl_fill] = in_item.coord_y;
              tbl_z[tbl_fill] = in_item.coord_z;
              tbl_fill++;
            end
          end
          OP_QUERY: predict_neighbors(in_item);
          OP_CLEAR: tbl_fill = 0;
          default: ;
        endcase
      end
      if (cfg_we) k_setting = cfg_wdata;
    end
    pending = neighbor_expect_q.size();
  end

endmodule

// File: sim/tb_top.sv
// Top of the k-nearest point select testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb_top;
  import knps_pkg::*;

  // The op encoding that the unit must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A full-table query keeps the unit busy through a scan of all MAX_POINTS entries with no
  // transaction on either channel, so the watchdog limit sits well above that.
  localparam int STALL_LIMIT = 10000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  int err_count;
  int pending;
  int results_seen;

  // Stimulus bookkeeping. fill_level mirrors the table occupancy so that queries can pick
  // skip indexes that name a stored point most of the time.
  int sender_idle_pct;
  int fill_level;
  int n_load;
  int n_query;
  int n_clear;
  int n_ignored;
  int stall_cycles;

  k_nearest_point_select_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  knps_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .err_count    (err_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always #5 clk = ~clk;

  // The watchdog restarts whenever a command is taken or a result appears. Anything that
  // hangs the unit, or a result that never arrives, ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("Watchdog expired with %0d neighbor results still outstanding.", pending);
      $display("[k_nearest_point_select_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t make_command(input logic [1:0] op, input int x, input int y,
                                            input int z, input bit skip_valid,
                                            input int skip_index);
    in_item_t c;
    c.op         = op;
    c.coord_x    = FIELD_COORD_W'(x);
    c.coord_y    = FIELD_COORD_W'(y);
    c.coord_z    = FIELD_COORD_W'(z);
    c.skip_valid = skip_valid;
    c.skip_index = FIELD_IDX_W'(skip_index);
    return c;
  endfunction

  // Clustered coordinates sit in a tiny cube so that equal distances, and thus the tie rule,
  // come up often; the rest spans the whole range with the extremes favored.
  function automatic int rand_coord(input bit clustered);
    if (clustered && $urandom_range(4) != 0) return int'($urandom_range(6)) - 3;
    case ($urandom_range(7))
      0:       return -32768;
      1:       return 32767;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // Called right after a rising edge. The command is presented after an optional random
  // gap and held until an edge where busy is low takes it. Busy only moves at rising edges,
  // so it is sampled at the falling edge in between to stay clear of any race.
  task automatic issue_command(input in_item_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= c;
    @(negedge clk);
    while (busy) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    case (c.op)
      OP_LOAD: begin
        n_load++;
        if (fill_level < MAX_POINTS) fill_level++;
      end
      OP_QUERY: n_query++;
      OP_CLEAR: begin
        n_clear++;
        fill_level = 0;
      end
      default: n_ignored++;
    endcase
  endtask

  // Lets the unit drain: nothing expected, busy low, and then a pause that covers a load,
  // clear or ignored command still in flight, which produces no result to wait for.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (busy || pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_neighbor_count(input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic issue_random_query(input bit clustered);
    int si;
    if (fill_level > 0 && $urandom_range(3) != 0) si = $urandom_range(fill_level - 1);
    else si = $urandom_range(1023);
    issue_command(make_command(OP_QUERY, rand_coord(clustered), rand_coord(clustered),
                               rand_coord(clustered), 1'($urandom_range(1)), si));
  endtask

  initial begin
    bit clustered;
    int pick;
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    sender_idle_pct = 0;
    fill_level      = 0;
    n_load          = 0;
    n_query         = 0;
    n_clear         = 0;
    n_ignored       = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run with the reset value of the neighbor count (three).
    // A query on an empty table must return nothing.
    issue_command(make_command(OP_QUERY, 0, 0, 0, 1'b0, 0));
    // Corner points of the coordinate range, the origin twice to force a tie, and a point
    // near the origin.
    issue_command(make_command(OP_LOAD, -32768, -32768, -32768, 1'b0, 0));
    issue_command(make_command(OP_LOAD, 32767, 32767, 32767, 1'b0, 0));
    issue_command(make_command(OP_LOAD, 0, 0, 0, 1'b0, 0));
    issue_command(make_command(OP_LOAD, 32767, -32768, 0, 1'b0, 0));
    issue_command(make_command(OP_LOAD, 0, 0, 0, 1'b0, 0));
    issue_command(make_command(OP_LOAD, -1, 1, -1, 1'b0, 0));
    // The far corner against the near corner gives the largest possible distance.
    issue_command(make_command(OP_QUERY, 32767, 32767, 32767, 1'b0, 0));
    issue_command(make_command(OP_QUERY, -32768, -32768, -32768, 1'b0, 0));
    // Origin query: the two stored origins tie and the earlier one must come first.
    issue_command(make_command(OP_QUERY, 0, 0, 0, 1'b0, 0));
    // Excluding the first origin leaves the second one at rank zero.
    issue_command(make_command(OP_QUERY, 0, 0, 0, 1'b1, 2));
    // A skip index beyond the stored points excludes nothing.
    issue_command(make_command(OP_QUERY, 0, 0, 0, 1'b1, 1023));
    // The unused op code must be ignored, with every field at all ones.
    issue_command(make_command(OP_UNUSED, -1, -1, -1, 1'b1, 1023));
    issue_command(make_command(OP_CLEAR, 0, 0, 0, 1'b0, 0));
    issue_command(make_command(OP_QUERY, 5, 5, 5, 1'b0, 0));
    // Fewer stored points than the neighbor count: the list is short and still ends with last.
    issue_command(make_command(OP_LOAD, 100, -200, 300, 1'b0, 0));
    issue_command(make_command(OP_LOAD, -100, 200, -300, 1'b0, 0));
    issue_command(make_command(OP_QUERY, 0, 0, 0, 1'b0, 0));
    issue_command(make_command(OP_QUERY, 0, 0, 0, 1'b1, 0));
    issue_command(make_command(OP_QUERY, 0, 0, 0, 1'b1, 1));

    // Random part in rounds. Each round starts from a drained unit with a new neighbor count,
    // sometimes on a fresh table, and mixes loads and queries with a little noise. The sender
    // idles often at first, then very often, then not at all.
    for (int round = 0; round < 12; round++) begin
      sender_idle_pct = (round < 4) ? 26 : (round < 8) ? 82 : 0;
      wait_drained();
      case (round % 6)
        0:       write_neighbor_count(CFG_W'(0));
        1:       write_neighbor_count(CFG_W'(16));
        2:       write_neighbor_count(CFG_W'(1));
        3:       write_neighbor_count(CFG_W'(31));
        4:       write_neighbor_count(CFG_W'(17));
        default: write_neighbor_count(CFG_W'($urandom_range(31)));
      endcase
      clustered = 1'($urandom_range(1));
      if (fill_level > 48 || $urandom_range(2) == 0)
        issue_command(make_command(OP_CLEAR, 0, 0, 0, 1'b0, 0));
      for (int n = 0; n < 12; n++) begin
        pick = $urandom_range(99);
        if (pick < 52)
          issue_command(make_command(OP_LOAD, rand_coord(clustered), rand_coord(clustered),
                                     rand_coord(clustered), 1'b0, 0));
        else if (pick < 92)
          issue_random_query(clustered);
        else if (pick < 96)
          issue_command(make_command(OP_UNUSED, rand_coord(1'b0), rand_coord(1'b0),
                                     rand_coord(1'b0), 1'($urandom_range(1)),
                                     $urandom_range(1023)));
        else
          issue_command(make_command(OP_CLEAR, 0, 0, 0, 1'b0, 0));
      end
    end

    // Close with the largest neighbor count on the table left by the last round, once
    // excluding its first stored point and once excluding nothing.
    wait_drained();
    write_neighbor_count(CFG_W'(16));
    issue_command(make_command(OP_QUERY, 0, 0, 0, 1'b1, 0));
    issue_command(make_command(OP_QUERY, 32767, -32768, 32767, 1'b1, 1023));
    issue_random_query(1'b0);

    wait_drained();
    $display("Run covered %0d loads, %0d queries, %0d clears and %0d ignored commands.",
             n_load, n_query, n_clear, n_ignored);
    $display("It checked %0d neighbor results over neighbor counts 0 to 31.",
             results_seen);
    if (err_count == 0 && pending == 0) begin
      $display("[k_nearest_point_select_unit] OK");
    end else begin
      $display("[k_nearest_point_select_unit] ERROR");
    end
    $finish;
  end

endmodule
